>>> sv/bed_pkg.sv
// Shared types, codes and helpers for the backslash escape decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bed_pkg;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_CSI = 8'h9B;
  localparam logic [7:0] CTL_ESC = 8'h1B;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0B;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_ESC      = 3'd1,
    MODE_HEX1     = 3'd2,
    MODE_HEX2     = 3'd3,
    MODE_HEX2_BAD = 3'd4,
    MODE_OCT      = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       line_done;
    logic       bad_hex;
    logic       run_last;
  } result_t;

  // Up to two results caused by one input byte.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] cnt;
  } pair_t;

  typedef struct packed {
    logic ok;
    logic [3:0] nib;
  } hex_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) return c + 8'd32;
    return c;
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.nib = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.nib = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  // Append one result to a pair; a third result is dropped.
  function automatic pair_t pair_add(input pair_t p, input logic [7:0] b,
                                     input logic has, input logic bad);
    pair_t   q;
    result_t r;
    q = p;
    r = '{out_byte: b, has_byte: has, line_done: 1'b0, bad_hex: bad, run_last: 1'b0};
    if (p.cnt == 2'd0) begin
      q.res0 = r;
      q.cnt  = 2'd1;
    end else if (p.cnt == 2'd1) begin
      q.res1 = r;
      q.cnt  = 2'd2;
    end
    return q;
  endfunction

endpackage

>>> sv/bed_front.sv
// Front end: accepts text bytes, runs the escape state and forms the results.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  bed_pkg::item_t    item,
  input  logic              full,
  output logic              item_stall,
  output logic              push,
  output bed_pkg::pair_t    pair
);
  import bed_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] acc, acc_next;
  logic [1:0] left, left_next;
  logic       accept;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign push       = accept && (pair.cnt != 2'd0);

  always_comb begin
    logic [7:0] b;
    logic [7:0] c;
    hex_t       hv;
    pair_t      p;
    logic       bad;
    b         = item.in_byte;
    c         = to_lower(b);
    hv        = hex_value(b);
    p         = '0;
    bad       = 1'b0;
    mode_next = mode;
    acc_next  = acc;
    left_next = left;
    case (mode)
      MODE_ESC: begin
        mode_next = MODE_IDLE;
        case (c)
          CH_NEWLINE: ;
          8'h62: p = pair_add(p, CTL_BS, 1'b1, 1'b0);
          8'h63: p = pair_add(p, CTL_CSI, 1'b1, 1'b0);
          8'h65: p = pair_add(p, CTL_ESC, 1'b1, 1'b0);
          8'h66: p = pair_add(p, CTL_FF, 1'b1, 1'b0);
          8'h67: p = pair_add(p, CTL_BEL, 1'b1, 1'b0);
          8'h6E: p = pair_add(p, CTL_LF, 1'b1, 1'b0);
          8'h72: p = pair_add(p, CTL_CR, 1'b1, 1'b0);
          8'h74: p = pair_add(p, CTL_TAB, 1'b1, 1'b0);
          8'h76: p = pair_add(p, CTL_VT, 1'b1, 1'b0);
          8'h78: mode_next = MODE_HEX1;
          CH_RPAREN, CH_BACKSLASH: begin
            p = pair_add(p, CH_BACKSLASH, 1'b1, 1'b0);
            p = pair_add(p, c, 1'b1, 1'b0);
          end
          default: begin
            if (c inside {[CH_ZERO:CH_SEVEN]}) begin
              acc_next  = {5'd0, c[2:0]};
              left_next = 2'd2;
              mode_next = MODE_OCT;
            end else begin
              p = pair_add(p, c, 1'b1, 1'b0);
            end
          end
        endcase
      end
      MODE_HEX1: begin
        if (hv.ok) begin
          acc_next  = {4'd0, hv.nib};
          mode_next = MODE_HEX2;
        end else begin
          acc_next  = 8'd0;
          mode_next = MODE_HEX2_BAD;
        end
      end
      MODE_HEX2, MODE_HEX2_BAD: begin
        bad       = (mode == MODE_HEX2_BAD);
        mode_next = MODE_IDLE;
        if (hv.ok) begin
          p = pair_add(p, {acc[3:0], hv.nib}, 1'b1, bad);
        end else begin
          p = pair_add(p, acc, 1'b1, bad);
          if (b == CH_BACKSLASH) mode_next = MODE_ESC;
          else p = pair_add(p, b, 1'b1, 1'b0);
        end
      end
      MODE_OCT: begin
        if (b inside {[CH_ZERO:CH_SEVEN]}) begin
          acc_next  = {acc[4:0], b[2:0]};
          left_next = (left != 2'd0) ? left - 2'd1 : 2'd0;
          if (left_next == 2'd0) begin
            mode_next = MODE_IDLE;
            p = pair_add(p, acc_next, 1'b1, 1'b0);
          end
        end else begin
          mode_next = MODE_IDLE;
          left_next = 2'd0;
          p = pair_add(p, acc, 1'b1, 1'b0);
          if (b == CH_BACKSLASH) mode_next = MODE_ESC;
          else p = pair_add(p, b, 1'b1, 1'b0);
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (b == CH_BACKSLASH) mode_next = MODE_ESC;
        else p = pair_add(p, b, 1'b1, 1'b0);
      end
    endcase

    // Flush any hex or octal escape still open at line end; a pending lone backslash is dropped.
    if (item.line_end) begin
      case (mode_next)
        MODE_HEX1:     p = pair_add(p, 8'd0, 1'b1, 1'b1);
        MODE_HEX2:     p = pair_add(p, acc_next, 1'b1, 1'b0);
        MODE_HEX2_BAD: p = pair_add(p, acc_next, 1'b1, 1'b1);
        MODE_OCT:      p = pair_add(p, acc_next, 1'b1, 1'b0);
        default: ;
      endcase
      mode_next = MODE_IDLE;
      acc_next  = 8'd0;
      left_next = 2'd0;
      if (p.cnt == 2'd0) p = pair_add(p, 8'd0, 1'b0, 1'b0);
      if (p.cnt == 2'd2) p.res1.line_done = 1'b1;
      else p.res0.line_done = 1'b1;
    end

    if (p.cnt == 2'd2) p.res1.run_last = 1'b1;
    else if (p.cnt == 2'd1) p.res0.run_last = 1'b1;
    pair = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc  <= 8'd0;
      left <= 2'd0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      left <= left_next;
    end
  end

endmodule

>>> sv/bed_queue.sv
// Short queue of result pairs between the front and back ends.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bed_pkg::pair_t       wr_pair,
  input  logic                 pop,
  output bed_pkg::pair_t       head,
  output bed_pkg::q_status_t   status
);
  import bed_pkg::*;

  pair_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head   = mem[rd_ptr];
  assign status = '{full: (count == QCNT_W'(QDEPTH)), empty: (count == '0)};

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/bed_back.sv
// Back end: drains result pairs from the queue into the output register.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bed_pkg::pair_t       head,
  input  bed_pkg::q_status_t   status,
  output logic                 pop,
  input  logic                 result_stall,
  output logic                 result_valid,
  output bed_pkg::result_t     result
);
  import bed_pkg::*;

  logic sel;
  logic load;
  logic take;

  assign load = !result_valid || !result_stall;
  assign take = load && !status.empty;
  // Advance to the second result of a pair, pop after its last one.
  assign pop  = take && (sel || head.cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sel          <= 1'b0;
    end else if (load) begin
      result_valid <= !status.empty;
      if (take) sel <= !sel && (head.cnt == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (take) result <= sel ? head.res1 : head.res0;
  end

  a_sel_has_entry: assert property (@(posedge clk) disable iff (rst)
    sel |-> !status.empty)
    else $error("second-result select set with queue empty");

  a_sel_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> head.cnt == 2'd2)
    else $error("second-result select on a single-result entry");

  a_no_empty_entry: assert property (@(posedge clk) disable iff (rst)
    !status.empty |-> head.cnt != 2'd0)
    else $error("queue entry holds no result");

  a_split_pair: assert property (@(posedge clk) disable iff (rst)
    (take && !sel && head.cnt == 2'd2) |=> sel && !result.run_last)
    else $error("pair not split across two transfers");

endmodule

>>> sv/backslash_escape_decoder.sv
// Top level of the backslash escape decoder: front end, queue, back end.
// Depends on bed_pkg, bed_front, bed_queue and bed_back.
`timescale 1ns / 1ps

// Channel   Signals                              Direction  Payload
// item      item_valid, item_stall, item         in         in_byte, line_end
// result    result_valid, result_stall, result   out        out_byte, has_byte, line_done,
//                                                           bad_hex, run_last
//
// One byte is taken per clock while item_stall is low; its results (none, one
// or two) are written to the queue and then loaded from the queue into the
// output register. The back end emits one result per clock while result_stall
// is low, so a byte that expands to two results leaves as two transfers; the
// four-entry queue absorbs short bursts, and a long run of such bytes stalls
// the input whenever the queue fills. Reset is synchronous and clears the
// escape state, the queue pointers and the output valid. item_stall rises
// only when the queue is full; result_stall holds the output register.

module backslash_escape_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bed_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output bed_pkg::result_t  result
);
  import bed_pkg::*;

  pair_t     wr_pair;
  pair_t     head;
  q_status_t status;
  logic      push;
  logic      pop;

  // Decode each transfer against the escape state and queue its results.
  bed_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .full       (status.full),
    .item_stall (item_stall),
    .push       (push),
    .pair       (wr_pair)
  );

  // Hold decoded pairs so that input and output stall independently.
  bed_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_pair (wr_pair),
    .pop     (pop),
    .head    (head),
    .status  (status)
  );

  // Drain one result per transfer into the output register.
  bed_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .status       (status),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
